/* rtl/core/lgs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg: shared constants for the life grid generation step block
// Request and result codes, register indexes, port widths and default sizes.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // fixed port widths
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int ACTION_W  = 2;
    localparam int COORD_W   = 6;

    // default grid bounds
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    typedef logic [ACTION_W-1:0]  action_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // request codes
    localparam action_t ACT_WRITE = 2'd0;
    localparam action_t ACT_READ  = 2'd1;
    localparam action_t ACT_STEP  = 2'd2;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // configuration register indexes
    localparam cfg_idx_t REG_GRID_WIDTH  = 1'd0;
    localparam cfg_idx_t REG_GRID_HEIGHT = 1'd1;

endpackage

/* rtl/core/lgs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ram: generic simple dual port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/lgs_row_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_row_unit: next generation of one grid row
// Counts the eight neighbors of every cell from three masked rows and
// applies the birth-on-three, survive-on-two-or-three rule in each lane.
// ----------------------------------------------------------------------------
module lgs_row_unit #(
    parameter int MAX_WIDTH = 64
) (
    input  logic [MAX_WIDTH-1:0] above,
    input  logic [MAX_WIDTH-1:0] cur,
    input  logic [MAX_WIDTH-1:0] below,
    input  logic [MAX_WIDTH-1:0] col_mask,
    input  logic                 row_ok,
    output logic [MAX_WIDTH-1:0] next_row
);

    logic [MAX_WIDTH+1:0] above_pad;
    logic [MAX_WIDTH+1:0] cur_pad;
    logic [MAX_WIDTH+1:0] below_pad;

    // dead cells beyond both edges
    assign above_pad = {1'b0, above, 1'b0};
    assign cur_pad   = {1'b0, cur, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    // one lane per column
    for (genvar c = 0; c < MAX_WIDTH; c++)
    begin : g_lane
        logic [3:0] cnt;

        assign cnt = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
                   + 4'(cur_pad[c]) + 4'(cur_pad[c+2])
                   + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);

        assign next_row[c] = row_ok && col_mask[c]
                           && ((cnt == 4'd3) || (cur[c] && (cnt == 4'd2)));
    end

endmodule

/* rtl/core/life_grid_generation_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_step_top: game of life grid with B3/S23 stepping
// Cell grid in a row-wide ram, single-cell write and read, and a row
// sweep that advances the whole grid by one generation.
// ----------------------------------------------------------------------------
// After reset the block clears the grid ram one row per cycle and holds
// busy high until the clear ends; configuration writes are taken at any
// time (cfg_ready is always high). A cell write reads the row, then writes
// the modified row back, and gives no result. A cell read gives its result
// strobe from the registered ram read, or without a ram read when the cell lies
// outside the grid size. A step sweeps every row through the single ram
// read port, one row per cycle, and raises its done strobe once the last row
// is written back. The done strobe lasts
// one cycle and cannot be held off; the receiver must take it.
module life_grid_generation_step_top #(
    parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic [lgs_pkg::ACTION_W-1:0]  action,
    input  logic [lgs_pkg::COORD_W-1:0]   col,
    input  logic [lgs_pkg::COORD_W-1:0]   row,
    input  logic                          alive_in,
    // result channel
    output logic                          done,
    output logic                          kind,
    output logic                          alive_out,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]     cfg_data
);

    import lgs_pkg::*;

    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int KW = $clog2(MAX_HEIGHT + 2);

    localparam logic [KW-1:0] K_LAST_CLR = KW'(MAX_HEIGHT - 1);
    localparam logic [KW-1:0] K_LAST_GEN = KW'(MAX_HEIGHT + 1);
    localparam logic [KW-1:0] K_ROWS     = KW'(MAX_HEIGHT);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_GEN   = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [MAX_WIDTH-1:0] above_reg, above_next;
    logic [MAX_WIDTH-1:0] cur_reg, cur_next;
    logic                 cur_ok_reg, cur_ok_next;
    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic                 done_reg, done_next;
    logic                 kind_reg, kind_next;
    logic                 alive_out_reg, alive_out_next;
    logic [COORD_W-1:0]   col_reg;
    logic [COORD_W-1:0]   row_reg;
    logic                 alive_reg;

    logic                 accept;
    logic                 in_grid;
    logic [31:0]          arr_idx;
    logic                 arr_ok;
    logic [MAX_WIDTH-1:0] col_mask;
    logic [MAX_WIDTH-1:0] below_row;
    logic [MAX_WIDTH-1:0] new_row;
    logic [MAX_WIDTH-1:0] mod_row;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [MAX_WIDTH-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [MAX_WIDTH-1:0] ram_rdata;

    // handshake
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign kind      = kind_reg;
    assign alive_out = alive_out_reg;

    // requested cell lies inside the grid size in use
    assign in_grid = (32'(col) < 32'(width_reg)) && (32'(col) < 32'(MAX_WIDTH))
                  && (32'(row) < 32'(height_reg)) && (32'(row) < 32'(MAX_HEIGHT));

    // columns in use
    for (genvar c = 0; c < MAX_WIDTH; c++)
    begin : g_mask
        assign col_mask[c] = (32'(c) < 32'(width_reg));
    end

    // row arriving from the ram during the sweep is row k - 1
    assign arr_idx   = 32'(k_reg) - 32'd1;
    assign arr_ok    = (arr_idx < 32'(MAX_HEIGHT)) && (arr_idx < 32'(height_reg));
    assign below_row = arr_ok ? (ram_rdata & col_mask) : '0;

    // shared row compute unit
    lgs_row_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_unit (
        .above    (above_reg),
        .cur      (cur_reg),
        .below    (below_row),
        .col_mask (col_mask),
        .row_ok   (cur_ok_reg),
        .next_row (new_row)
    );

    // single cell update of the fetched row
    always_comb
    begin
        mod_row = ram_rdata;
        mod_row[CW'(col_reg)] = alive_reg;
    end

    // grid storage
    lgs_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        above_next     = above_reg;
        cur_next       = cur_reg;
        cur_ok_next    = cur_ok_reg;
        done_next      = 1'b0;
        kind_next      = kind_reg;
        alive_out_next = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = AW'(k_reg);
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = AW'(row);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                k_next = k_reg + KW'(1);
                if (k_reg == K_LAST_CLR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (action == ACT_WRITE)
                    begin
                        if (in_grid)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_WRITE;
                        end
                    end
                    else if (action == ACT_READ)
                    begin
                        if (in_grid)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            done_next = 1'b1;
                            kind_next = KIND_READ;
                        end
                    end
                    else if (action == ACT_STEP)
                    begin
                        k_next      = '0;
                        above_next  = '0;
                        cur_next    = '0;
                        cur_ok_next = 1'b0;
                        state_next  = S_GEN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(row_reg);
                ram_wdata  = mod_row;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                done_next      = 1'b1;
                kind_next      = KIND_READ;
                alive_out_next = ram_rdata[CW'(col_reg)];
                state_next     = S_IDLE;
            end
            S_GEN:
            begin
                // fetch row k
                ram_re    = (k_reg < K_ROWS);
                ram_raddr = AW'(k_reg);
                // write back row k - 2
                ram_we    = (k_reg >= KW'(2));
                ram_waddr = AW'(k_reg - KW'(2));
                ram_wdata = new_row;
                // slide the three-row window
                above_next  = cur_reg;
                cur_next    = below_row;
                cur_ok_next = arr_ok;
                k_next      = k_reg + KW'(1);
                if (k_reg == K_LAST_GEN)
                begin
                    done_next  = 1'b1;
                    kind_next  = KIND_STEP;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            k_reg         <= '0;
            cur_ok_reg    <= 1'b0;
            done_reg      <= 1'b0;
            kind_reg      <= KIND_READ;
            alive_out_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cur_ok_reg    <= cur_ok_next;
            done_reg      <= done_next;
            kind_reg      <= kind_next;
            alive_out_reg <= alive_out_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(64);
            height_reg <= CFG_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_GRID_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == REG_GRID_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // row window and request payload
    always_ff @(posedge clk)
    begin
        above_reg <= above_next;
        cur_reg   <= cur_next;
        if (accept)
        begin
            col_reg   <= col;
            row_reg   <= row;
            alive_reg <= alive_in;
        end
    end

    // sweep starts with an empty window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GEN && k_reg == '0) |-> (above_reg == '0 && cur_reg == '0))
        else $error("row window not cleared at sweep start");

    // a step result only ends a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind == KIND_STEP) |-> ($past(state_reg) == S_GEN && !alive_out))
        else $error("step result outside a sweep");

    // reads outside the grid reply dead
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind == KIND_READ && $past(state_reg) == S_IDLE) |-> !alive_out)
        else $error("outside read returned a live cell");

    // the sweep never reads a row in the cycle it is rewritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram read and write collide");

    // nothing written to the grid while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("grid write while idle");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: life grid generation step top
// Sends cell writes, cell reads and generation steps over a range of grid
// sizes, keeps its own copy of the grid to predict every read reply and step
// completion, and checks each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import lgs_pkg::*;

    localparam int GRID_MAX      = 64;
    localparam int CLK_HALF      = 4;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 2 * GRID_MAX;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SWEEP_CELLS   = 100;

    // code that the block leaves unused
    localparam action_t ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic kind;
        logic alive;
    } grid_reply_t;

    // block ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    action_t              action    = ACT_WRITE;
    logic [COORD_W-1:0]   col       = '0;
    logic [COORD_W-1:0]   row       = '0;
    logic                 alive_in  = 1'b0;
    logic                 done;
    logic                 kind;
    logic                 alive_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = REG_GRID_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // predicted grid and sizes
    logic [GRID_MAX-1:0]  model_cells [GRID_MAX];
    logic [CFG_W-1:0]     model_width  = CFG_W'(GRID_MAX);
    logic [CFG_W-1:0]     model_height = CFG_W'(GRID_MAX);

    grid_reply_t          pending_replies [$];
    int unsigned          mismatch_count = 0;
    int unsigned          applied_items  = 0;
    bit                   burst_mode     = 1'b0;

    life_grid_generation_step_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .col       (col),
        .row       (row),
        .alive_in  (alive_in),
        .done      (done),
        .kind      (kind),
        .alive_out (alive_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    initial
    begin
        foreach (model_cells[i])
        begin
            model_cells[i] = '0;
        end
    end

    // size register clamped to the grid bound
    function automatic int used_span(input logic [CFG_W-1:0] value);
        return (value > GRID_MAX) ? GRID_MAX : int'(value);
    endfunction

    // random coordinate within a span, full range when the span is empty
    function automatic logic [COORD_W-1:0] pick_coord(input int span);
        if (span == 0)
            return COORD_W'($urandom_range(0, GRID_MAX - 1));
        return COORD_W'($urandom_range(0, span - 1));
    endfunction

    // add one prediction at the tail of the reply queue
    task automatic queue_reply(input grid_reply_t reply);
        pending_replies.insert(pending_replies.size(), reply);
    endtask

    // one B3/S23 generation computed from a snapshot of the old grid
    task automatic advance_model_grid();
        logic [GRID_MAX-1:0] prev_cells [GRID_MAX];
        int w, h, r, c, dr, dc, nr, nc, live;
        w = used_span(model_width);
        h = used_span(model_height);
        prev_cells = model_cells;
        for (r = 0; r < GRID_MAX; r++)
        begin
            for (c = 0; c < GRID_MAX; c++)
            begin
                if (r >= h || c >= w)
                begin
                    model_cells[r][c] = 1'b0;
                end
                else
                begin
                    live = 0;
                    for (dr = -1; dr <= 1; dr++)
                    begin
                        for (dc = -1; dc <= 1; dc++)
                        begin
                            nr = r + dr;
                            nc = c + dc;
                            if ((dr != 0 || dc != 0) && nr >= 0 && nr < h
                                && nc >= 0 && nc < w)
                                live += prev_cells[nr][nc];
                        end
                    end
                    model_cells[r][c] = (live == 3) || (prev_cells[r][c] && live == 2);
                end
            end
        end
    endtask

    // update the grid copy for one accepted request and queue its reply
    task automatic apply_request(input action_t act, input logic [COORD_W-1:0] cell_col,
                                 input logic [COORD_W-1:0] cell_row, input logic value);
        grid_reply_t reply;
        bit in_use;
        in_use = (cell_col < used_span(model_width)) && (cell_row < used_span(model_height));
        case (act)
            ACT_WRITE:
            begin
                if (in_use)
                begin
                    model_cells[cell_row][cell_col] = value;
                end
            end
            ACT_READ:
            begin
                reply.kind  = KIND_READ;
                reply.alive = in_use ? model_cells[cell_row][cell_col] : 1'b0;
                queue_reply(reply);
            end
            ACT_STEP:
            begin
                advance_model_grid();
                reply.kind  = KIND_STEP;
                reply.alive = 1'b0;
                queue_reply(reply);
            end
            default:
            begin
            end
        endcase
    endtask

    // one request transfer; start stays high so a back-to-back request needs no toggle
    task automatic send_request(input action_t act, input logic [COORD_W-1:0] cell_col,
                                input logic [COORD_W-1:0] cell_row, input logic value);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        action   <= act;
        col      <= cell_col;
        row      <= cell_row;
        alive_in <= value;
        do @(posedge clk); while (busy);
        apply_request(act, cell_col, cell_row, value);
        applied_items++;
    endtask

    // stop sending and wait until the block has nothing left to report
    task automatic drain_results();
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // write both size registers while the block is idle
    task automatic set_grid_size(input logic [CFG_W-1:0] new_width,
                                 input logic [CFG_W-1:0] new_height);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= new_width;
        do @(posedge clk); while (!cfg_ready);
        model_width = new_width;
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data  <= new_height;
        do @(posedge clk); while (!cfg_ready);
        model_height = new_height;
        cfg_valid <= 1'b0;
    endtask

    // occasional malformed request and occasional full drain
    task automatic maybe_noise();
        if ($urandom_range(0, 11) == 0)
            send_request(action_t'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 63)),
                         COORD_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 39) == 0)
            drain_results();
    endtask

    // read every cell of a small grid plus one column and row past its far edges, else sample
    task automatic read_sweep();
        int cols, rows, r, c;
        cols = used_span(model_width) + 1;
        rows = used_span(model_height) + 1;
        if (cols > GRID_MAX)
            cols = GRID_MAX;
        if (rows > GRID_MAX)
            rows = GRID_MAX;
        if (cols * rows <= SWEEP_CELLS)
        begin
            for (r = 0; r < rows; r++)
            begin
                for (c = 0; c < cols; c++)
                begin
                    maybe_noise();
                    send_request(ACT_READ, COORD_W'(c), COORD_W'(r), 1'($urandom_range(0, 1)));
                end
            end
        end
        else
        begin
            repeat (24)
            begin
                maybe_noise();
                send_request(ACT_READ, COORD_W'($urandom_range(0, 63)),
                             COORD_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // result checker: every strobe must match the oldest prediction
    always @(posedge clk)
    begin
        grid_reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result: kind %0d alive_out %0d", kind, alive_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                    mismatch_count++;
                end
                if (alive_out !== want.alive)
                begin
                    $error("alive_out mismatch: expected %0d, actual %0d",
                           want.alive, alive_out);
                    mismatch_count++;
                end
            end
        end
    end

    // reset values of the grid at the default size
    task automatic test_reset_state();
        send_request(ACT_READ, 6'd0, 6'd0, 1'b1);
        send_request(ACT_READ, 6'd63, 6'd63, 1'b0);
        send_request(ACT_READ, 6'd0, 6'd63, 1'b1);
    endtask

    // single-cell writes and reads at the corners and the middle, plus the unused code
    task automatic test_cell_access();
        send_request(ACT_WRITE, 6'd63, 6'd63, 1'b1);
        send_request(ACT_WRITE, 6'd0, 6'd0, 1'b1);
        send_request(ACT_WRITE, 6'd31, 6'd32, 1'b1);
        send_request(ACT_READ, 6'd63, 6'd63, 1'b0);
        send_request(ACT_READ, 6'd31, 6'd32, 1'b0);
        send_request(ACT_WRITE, 6'd0, 6'd0, 1'b0);
        send_request(ACT_READ, 6'd0, 6'd0, 1'b1);
        send_request(ACT_UNUSED, 6'd63, 6'd63, 1'b1);
        send_request(ACT_READ, 6'd63, 6'd63, 1'b0);
    endtask

    // shrinking hides cells without clearing them, sizes above the bound clamp
    task automatic test_size_change();
        set_grid_size(7'd3, 7'd3);
        send_request(ACT_READ, 6'd63, 6'd63, 1'b0);
        send_request(ACT_WRITE, 6'd5, 6'd5, 1'b1);
        send_request(ACT_READ, 6'd5, 6'd5, 1'b0);
        set_grid_size(7'd127, 7'd100);
        send_request(ACT_READ, 6'd63, 6'd63, 1'b0);
    endtask

    // empty grid: writes dropped, reads zero, a step clears everything
    task automatic test_zero_size();
        set_grid_size(7'd0, 7'd64);
        send_request(ACT_READ, 6'd0, 6'd0, 1'b0);
        send_request(ACT_WRITE, 6'd1, 6'd1, 1'b1);
        send_request(ACT_STEP, 6'd0, 6'd0, 1'b0);
        set_grid_size(7'd64, 7'd64);
        send_request(ACT_READ, 6'd63, 6'd63, 1'b0);
    endtask

    // vertical blinker on a 3x3 grid turns horizontal, edges count as dead
    task automatic test_blinker();
        set_grid_size(7'd3, 7'd3);
        send_request(ACT_WRITE, 6'd1, 6'd0, 1'b1);
        send_request(ACT_WRITE, 6'd1, 6'd1, 1'b1);
        send_request(ACT_WRITE, 6'd1, 6'd2, 1'b1);
        send_request(ACT_STEP, 6'd0, 6'd0, 1'b0);
        send_request(ACT_READ, 6'd0, 6'd1, 1'b0);
        send_request(ACT_READ, 6'd1, 6'd0, 1'b0);
    endtask

    // random phases: seed a grid, then steps each followed by a read sweep
    task automatic test_random_phases();
        int unsigned goal, sel, steps;
        logic [CFG_W-1:0] phase_width, phase_height;
        goal = applied_items + RANDOM_ITEMS;
        while (applied_items < goal)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:
                begin
                    phase_width  = '0;
                    phase_height = CFG_W'($urandom_range(0, 127));
                end
                1:
                begin
                    phase_width  = CFG_W'($urandom_range(0, 127));
                    phase_height = '0;
                end
                2:
                begin
                    phase_width  = CFG_W'(GRID_MAX);
                    phase_height = CFG_W'(GRID_MAX);
                end
                3:
                begin
                    phase_width  = CFG_W'($urandom_range(0, 127));
                    phase_height = CFG_W'($urandom_range(0, 127));
                end
                default:
                begin
                    phase_width  = CFG_W'($urandom_range(1, 12));
                    phase_height = CFG_W'($urandom_range(1, 12));
                end
            endcase
            set_grid_size(phase_width, phase_height);
            burst_mode = ($urandom_range(0, 3) == 0);

            // seed pattern
            repeat ($urandom_range(4, 24))
            begin
                maybe_noise();
                send_request(ACT_WRITE, pick_coord(used_span(model_width)),
                             pick_coord(used_span(model_height)), 1'($urandom_range(0, 1)));
            end

            // steps, cut short once enough items have gone out
            steps = $urandom_range(1, 4);
            while (steps != 0 && applied_items < goal)
            begin
                repeat ($urandom_range(0, 4))
                begin
                    send_request(ACT_WRITE, pick_coord(used_span(model_width)),
                                 pick_coord(used_span(model_height)),
                                 1'($urandom_range(0, 1)));
                end
                send_request(ACT_STEP, COORD_W'($urandom_range(0, 63)),
                             COORD_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                // sometimes shrink and grow back before the next step
                if ($urandom_range(0, 3) == 0)
                begin
                    set_grid_size(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)));
                    read_sweep();
                    set_grid_size(phase_width, phase_height);
                end
                read_sweep();
                steps--;
            end
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        int unsigned drain_wait;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_cell_access();
        test_size_change();
        test_zero_size();
        test_blinker();
        test_random_phases();

        // let the last results arrive, bounded
        start <= 1'b0;
        drain_wait = 0;
        while (pending_replies.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (pending_replies.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_replies.size());
            mismatch_count++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/lgs_pkg.sv
rtl/core/lgs_ram.sv
rtl/core/lgs_row_unit.sv
rtl/core/life_grid_generation_step_top.sv
tb/sv/testbench.sv
